@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define QRS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define QRS_ASSERT(lbl, prop, msg) \
  `QRS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/qrs_pkg.sv @@
// Shared types, widths and codes of the quadratic root solver.
package qrs_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TOL_WIDTH   = 16;

  localparam int PRODW = 2 * VALUE_WIDTH;        // product of two magnitudes
  localparam int DW    = 2 * VALUE_WIDTH + 1;    // discriminant magnitude
  localparam int SW    = VALUE_WIDTH + 1;        // square root
  localparam int RADW  = 2 * SW;                 // padded radicand
  localparam int SRW   = SW + 3;                 // square root remainder
  localparam int NW    = SW + 2;                 // signed numerator
  localparam int NMW   = SW + 1;                 // numerator magnitude
  localparam int DENW  = VALUE_WIDTH + 1;        // denominator magnitude
  localparam int XW    = NMW + FRAC_BITS;        // scaled dividend
  localparam int QW    = XW;                     // full quotient

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_TWO  = 2'd2;
  localparam logic [1:0] KIND_INF  = 2'd3;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_INF,
    MODE_ZERO,
    MODE_SINGLE,
    MODE_ZERO_PAIR,
    MODE_PAIR
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [NW-1:0]         num;
    logic [DENW-1:0]       den_mag;
    logic                  den_neg;
    logic [DW-1:0]         disc;
  } job_t;

  function automatic logic [VALUE_WIDTH-1:0] mag_of(input logic [VALUE_WIDTH-1:0] v);
    return v[VALUE_WIDTH-1] ? VALUE_WIDTH'(VALUE_WIDTH'(0) - v) : v;
  endfunction

endpackage

@@ rtl/qrs_fifo.sv @@
// Short queue of classified items between the front and back parts.
module qrs_fifo import qrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/qrs_front.sv @@
// Front part: accepts coefficients, forms the discriminant and classifies the item.
module qrs_front import qrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] coef_quad_i,
  input  logic [VALUE_WIDTH-1:0] coef_lin_i,
  input  logic [VALUE_WIDTH-1:0] coef_const_i,
  input  logic                   cfg_we_i,
  input  logic [TOL_WIDTH-1:0]   cfg_zero_tolerance_i,
  output logic                   job_valid_o,
  output job_t                   job_o,
  input  logic                   job_ready_i
);

  logic                   fe;
  logic [TOL_WIDTH-1:0]   tol_q;

  logic                   s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [VALUE_WIDTH-1:0] s1_ma_q, s1_mb_q, s1_mc_q;
  logic                   s1_sa_q, s1_sb_q, s1_sc_q;
  logic [TOL_WIDTH-1:0]   s1_tol_q, s2_tol_q, s3_tol_q;

  logic [VALUE_WIDTH-1:0] s2_ma_q, s2_mb_q, s2_mc_q;
  logic                   s2_sa_q, s2_sb_q, s2_sc_q;
  logic                   s2_nza_q, s2_nzb_q, s2_nzc_q;
  logic [PRODW-1:0]       s2_bb_q, s2_ac_q;

  logic [VALUE_WIDTH-1:0] s3_ma_q, s3_mb_q, s3_mc_q;
  logic                   s3_sa_q, s3_sb_q, s3_sc_q;
  logic                   s3_nza_q, s3_nzb_q, s3_nzc_q;
  logic [DW:0]            s3_raw_q;

  logic [DW:0]            bbx, ac4;
  logic                   dneg, dsmall;
  logic [DW-1:0]          dmag;
  job_t                   job_d, job_q;

  assign fe          = !s4_vld_q || job_ready_i;
  assign in_ready_o  = fe;
  assign job_valid_o = s4_vld_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= TOL_WIDTH'(1);
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_zero_tolerance_i;
      end
      if (fe) begin
        s1_vld_q <= in_valid_i;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= s2_vld_q;
        s4_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      s1_ma_q  <= mag_of(coef_quad_i);
      s1_mb_q  <= mag_of(coef_lin_i);
      s1_mc_q  <= mag_of(coef_const_i);
      s1_sa_q  <= coef_quad_i[VALUE_WIDTH-1];
      s1_sb_q  <= coef_lin_i[VALUE_WIDTH-1];
      s1_sc_q  <= coef_const_i[VALUE_WIDTH-1];
      s1_tol_q <= tol_q;

      s2_ma_q  <= s1_ma_q;
      s2_mb_q  <= s1_mb_q;
      s2_mc_q  <= s1_mc_q;
      s2_sa_q  <= s1_sa_q;
      s2_sb_q  <= s1_sb_q;
      s2_sc_q  <= s1_sc_q;
      s2_tol_q <= s1_tol_q;
      s2_nza_q <= (s1_ma_q <= VALUE_WIDTH'(s1_tol_q));
      s2_nzb_q <= (s1_mb_q <= VALUE_WIDTH'(s1_tol_q));
      s2_nzc_q <= (s1_mc_q <= VALUE_WIDTH'(s1_tol_q));
      s2_bb_q  <= PRODW'(s1_mb_q) * PRODW'(s1_mb_q);
      s2_ac_q  <= PRODW'(s1_ma_q) * PRODW'(s1_mc_q);

      s3_ma_q  <= s2_ma_q;
      s3_mb_q  <= s2_mb_q;
      s3_mc_q  <= s2_mc_q;
      s3_sa_q  <= s2_sa_q;
      s3_sb_q  <= s2_sb_q;
      s3_sc_q  <= s2_sc_q;
      s3_tol_q <= s2_tol_q;
      s3_nza_q <= s2_nza_q;
      s3_nzb_q <= s2_nzb_q;
      s3_nzc_q <= s2_nzc_q;
      s3_raw_q <= (s2_sa_q != s2_sc_q) ? bbx + ac4 : bbx - ac4;

      job_q    <= job_d;
    end
  end

  assign bbx = (DW+1)'(s2_bb_q);
  assign ac4 = {s2_ac_q, 2'b00};

  always_comb begin
    dneg   = s3_raw_q[DW];
    dmag   = dneg ? DW'((DW+1)'(0) - s3_raw_q) : s3_raw_q[DW-1:0];
    dsmall = (dmag <= (DW'(s3_tol_q) << FRAC_BITS));

    job_d.mode    = MODE_NONE;
    job_d.num     = s3_sb_q ? NW'(s3_mb_q) : NW'(NW'(0) - NW'(s3_mb_q));
    job_d.den_mag = {s3_ma_q, 1'b0};
    job_d.den_neg = s3_sa_q;
    job_d.disc    = '0;

    if (s3_nza_q) begin
      if (s3_nzb_q) begin
        job_d.mode = s3_nzc_q ? MODE_INF : MODE_NONE;
      end else begin
        job_d.mode    = s3_nzc_q ? MODE_ZERO : MODE_SINGLE;
        job_d.num     = s3_sc_q ? NW'(s3_mc_q) : NW'(NW'(0) - NW'(s3_mc_q));
        job_d.den_mag = DENW'(s3_mb_q);
        job_d.den_neg = s3_sb_q;
      end
    end else if (s3_nzc_q) begin
      job_d.mode    = s3_nzb_q ? MODE_ZERO : MODE_ZERO_PAIR;
      job_d.den_mag = DENW'(s3_ma_q);
    end else if (dsmall) begin
      job_d.mode = MODE_SINGLE;
    end else if (dneg) begin
      job_d.mode = MODE_NONE;
    end else begin
      job_d.mode = MODE_PAIR;
      job_d.disc = dmag;
    end
  end

endmodule

@@ rtl/qrs_sqrt.sv @@
// Pipelined integer square root of the discriminant, one result bit per stage.
module qrs_sqrt import qrs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  job_t          job_i,
  output logic          vld_o,
  output job_t          job_o,
  output logic [SW-1:0] root_o
);

  logic            vld_q  [SW];
  job_t            job_q  [SW];
  logic [SW-1:0]   root_q [SW];
  logic [SRW-1:0]  rem_q  [SW];
  logic [RADW-1:0] rad_q  [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic [SRW-1:0]  rem_in, r2, trial;
    logic [SW-1:0]   root_in;
    logic [RADW-1:0] rad_in;
    job_t            job_in;
    logic            vld_in, ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = RADW'(job_i.disc);
      assign job_in  = job_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign job_in  = job_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign r2    = {rem_in[SRW-3:0], rad_in[RADW-1 -: 2]};
    assign trial = SRW'({root_in, 2'b01});
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? r2 - trial : r2;
        root_q[i] <= {root_in[SW-2:0], ge};
        rad_q[i]  <= {rad_in[RADW-3:0], 2'b00};
        job_q[i]  <= job_in;
      end
    end
  end

  assign vld_o  = vld_q[SW-1];
  assign job_o  = job_q[SW-1];
  assign root_o = root_q[SW-1];

endmodule

@@ rtl/qrs_div.sv @@
// Pipelined restoring divider of the scaled numerator, one quotient bit per stage.
module qrs_div import qrs_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NMW-1:0]  num_i,
  input  logic [DENW-1:0] den_i,
  input  logic            neg_i,
  output logic [QW-1:0]   quo_o,
  output logic            neg_o
);

  logic [DENW-1:0] rem_q [QW];
  logic [DENW-1:0] den_q [QW];
  logic [XW-1:0]   x_q   [QW];
  logic [QW-1:0]   quo_q [QW];
  logic            neg_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DENW-1:0] rem_in, den_in;
    logic [XW-1:0]   x_in;
    logic [QW-1:0]   quo_in;
    logic            neg_in, ge;
    logic [DENW:0]   r2;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign x_in   = {num_i, {FRAC_BITS{1'b0}}};
      assign quo_in = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign x_in   = x_q[i-1];
      assign quo_in = quo_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign r2 = {rem_in, x_in[XW-1]};
    assign ge = (r2 >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? DENW'(r2 - {1'b0, den_in}) : DENW'(r2);
        den_q[i] <= den_in;
        x_q[i]   <= {x_in[XW-2:0], 1'b0};
        quo_q[i] <= {quo_in[QW-2:0], ge};
        neg_q[i] <= neg_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];
  assign neg_o = neg_q[QW-1];

endmodule

@@ rtl/qrs_back.sv @@
// Back part: square root, two quotients, clipping and ordering of the roots.
module qrs_back import qrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  job_t                   job_i,
  output logic                   job_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             root_kind_o,
  output logic [VALUE_WIDTH-1:0] root_low_o,
  output logic [VALUE_WIDTH-1:0] root_high_o,
  output logic                   saturated_o
);

  localparam int W = VALUE_WIDTH;

  logic            be;
  logic            sq_vld;
  job_t            sq_job;
  logic [SW-1:0]   sq_root;
  logic [NW-1:0]   num_a, num_b;

  logic            nm_vld_q;
  mode_e           nm_mode_q;
  logic [NMW-1:0]  nm_mag_a_q, nm_mag_b_q;
  logic            nm_neg_a_q, nm_neg_b_q;
  logic [DENW-1:0] nm_den_q;

  logic [QW-1:0]   quo_a, quo_b;
  logic            neg_a, neg_b;
  logic            dv_q   [QW];
  mode_e           dm_q   [QW];

  logic            fx_vld_q;
  mode_e           fx_mode_q;
  logic [W-1:0]    fx_a_q, fx_b_q;
  logic            fx_sat_a_q, fx_sat_b_q;
  logic [W:0]      clip_a, clip_b;

  logic            out_vld_q, sat_q, sat_d;
  logic [1:0]      kind_q, kind_d;
  logic [W-1:0]    lo_q, hi_q, lo_d, hi_d;

  function automatic logic [W:0] clip(input logic [QW-1:0] quo, input logic neg);
    logic [QW-1:0] lim;
    logic          sat;
    logic [W-1:0]  qc;
    lim = neg ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
    sat = (quo > lim);
    qc  = sat ? lim[W-1:0] : quo[W-1:0];
    return {sat, (neg ? W'(W'(0) - qc) : qc)};
  endfunction

  assign be          = !out_vld_q || out_ready_i;
  assign job_ready_o = be;

  qrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (be),
    .vld_i  (job_valid_i),
    .job_i  (job_i),
    .vld_o  (sq_vld),
    .job_o  (sq_job),
    .root_o (sq_root)
  );

  assign num_a = sq_job.num - NW'(sq_root);
  assign num_b = sq_job.num + NW'(sq_root);

  always_ff @(posedge clk_i) begin
    if (be) begin
      nm_mode_q  <= sq_job.mode;
      nm_den_q   <= sq_job.den_mag;
      nm_mag_a_q <= num_a[NW-1] ? NMW'(NW'(0) - num_a) : num_a[NMW-1:0];
      nm_mag_b_q <= num_b[NW-1] ? NMW'(NW'(0) - num_b) : num_b[NMW-1:0];
      nm_neg_a_q <= num_a[NW-1] ^ sq_job.den_neg;
      nm_neg_b_q <= num_b[NW-1] ^ sq_job.den_neg;
    end
  end

  qrs_div u_div_a (
    .clk_i (clk_i),
    .en_i  (be),
    .num_i (nm_mag_a_q),
    .den_i (nm_den_q),
    .neg_i (nm_neg_a_q),
    .quo_o (quo_a),
    .neg_o (neg_a)
  );

  qrs_div u_div_b (
    .clk_i (clk_i),
    .en_i  (be),
    .num_i (nm_mag_b_q),
    .den_i (nm_den_q),
    .neg_i (nm_neg_b_q),
    .quo_o (quo_b),
    .neg_o (neg_b)
  );

  always_ff @(posedge clk_i) begin
    if (be) begin
      dm_q[0] <= nm_mode_q;
      for (int k = 1; k < QW; k++) begin
        dm_q[k] <= dm_q[k-1];
      end
    end
  end

  assign clip_a = clip(quo_a, neg_a);
  assign clip_b = clip(quo_b, neg_b);

  always_ff @(posedge clk_i) begin
    if (be) begin
      fx_mode_q  <= dm_q[QW-1];
      fx_a_q     <= clip_a[W-1:0];
      fx_b_q     <= clip_b[W-1:0];
      fx_sat_a_q <= clip_a[W];
      fx_sat_b_q <= clip_b[W];
    end
  end

  always_comb begin
    kind_d = KIND_NONE;
    lo_d   = '0;
    hi_d   = '0;
    sat_d  = 1'b0;
    unique case (fx_mode_q)
      MODE_NONE: begin
        kind_d = KIND_NONE;
      end
      MODE_INF: begin
        kind_d = KIND_INF;
      end
      MODE_ZERO: begin
        kind_d = KIND_ONE;
      end
      MODE_SINGLE: begin
        kind_d = KIND_ONE;
        lo_d   = fx_a_q;
        hi_d   = fx_a_q;
        sat_d  = fx_sat_a_q;
      end
      MODE_ZERO_PAIR: begin
        kind_d = KIND_TWO;
        sat_d  = fx_sat_a_q;
        if (fx_a_q[W-1]) begin
          lo_d = fx_a_q;
        end else begin
          hi_d = fx_a_q;
        end
      end
      MODE_PAIR: begin
        kind_d = KIND_TWO;
        sat_d  = fx_sat_a_q || fx_sat_b_q;
        if ($signed(fx_a_q) < $signed(fx_b_q)) begin
          lo_d = fx_a_q;
          hi_d = fx_b_q;
        end else begin
          lo_d = fx_b_q;
          hi_d = fx_a_q;
        end
      end
      default: begin
        kind_d = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q  <= 1'b0;
      fx_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < QW; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (be) begin
      nm_vld_q  <= sq_vld;
      dv_q[0]   <= nm_vld_q;
      for (int k = 1; k < QW; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      fx_vld_q  <= dv_q[QW-1];
      out_vld_q <= fx_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      kind_q <= kind_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign root_kind_o = kind_q;
  assign root_low_o  = lo_q;
  assign root_high_o = hi_q;
  assign saturated_o = sat_q;

endmodule

@@ rtl/quadratic_root_solver.sv @@
// Quadratic root solver top level: front part, item queue and back part.
// Real roots of a*x*x + b*x + c = 0 for signed Q16.16 coefficients. One item is
// accepted and one result leaves every cycle unless back-pressure stalls the
// pipeline; results are also Q16.16. The back part holds the one-bit-per-stage
// square root (VALUE_WIDTH+1 stages) and the two one-bit-per-stage dividers
// (VALUE_WIDTH+FRAC_BITS+2 stages). A four-item queue lets the front part keep
// accepting while the back part is stalled. The user must write zero_tolerance
// through cfg_we_i only while the block is idle; the block does not enforce it.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] coef_quad_i,
  input  logic [VALUE_WIDTH-1:0] coef_lin_i,
  input  logic [VALUE_WIDTH-1:0] coef_const_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             root_kind_o,
  output logic [VALUE_WIDTH-1:0] root_low_o,
  output logic [VALUE_WIDTH-1:0] root_high_o,
  output logic                   saturated_o,
  input  logic                   cfg_we_i,
  input  logic [TOL_WIDTH-1:0]   cfg_zero_tolerance_i
);

  logic job_valid, fifo_full, fifo_empty, back_ready;
  job_t job_front, job_back;

  qrs_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .coef_quad_i          (coef_quad_i),
    .coef_lin_i           (coef_lin_i),
    .coef_const_i         (coef_const_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_zero_tolerance_i (cfg_zero_tolerance_i),
    .job_valid_o          (job_valid),
    .job_o                (job_front),
    .job_ready_i          (!fifo_full)
  );

  qrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job_front),
    .full_o  (fifo_full),
    .pop_i   (back_ready),
    .data_o  (job_back),
    .empty_o (fifo_empty)
  );

  qrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!fifo_empty),
    .job_i       (job_back),
    .job_ready_o (back_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_kind_o (root_kind_o),
    .root_low_o  (root_low_o),
    .root_high_o (root_high_o),
    .saturated_o (saturated_o)
  );

endmodule

@@ rtl/qrs_checker.sv @@
// Port-level checker of the quadratic root solver and its bind.
`include "assert_macros.svh"

module qrs_checker import qrs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [VALUE_WIDTH-1:0] coef_quad_i,
  input logic [VALUE_WIDTH-1:0] coef_lin_i,
  input logic [VALUE_WIDTH-1:0] coef_const_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [1:0]             root_kind_o,
  input logic [VALUE_WIDTH-1:0] root_low_o,
  input logic [VALUE_WIDTH-1:0] root_high_o,
  input logic                   saturated_o,
  input logic                   cfg_we_i,
  input logic [TOL_WIDTH-1:0]   cfg_zero_tolerance_i
);

  `QRS_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> out_valid_o, "result item dropped while stalled")
  `QRS_ASSERT(a_no_roots_clear, (out_valid_o && (root_kind_o == KIND_NONE || root_kind_o == KIND_INF)) |-> (root_low_o == '0 && root_high_o == '0 && !saturated_o), "roots set without a finite root")
  `QRS_ASSERT(a_one_root_equal, (out_valid_o && root_kind_o == KIND_ONE) |-> (root_low_o == root_high_o), "single root differs")
  `QRS_ASSERT(a_two_roots_order, (out_valid_o && root_kind_o == KIND_TWO) |-> ($signed(root_low_o) <= $signed(root_high_o)), "roots out of order")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the quadratic root solver.
`timescale 1ns / 100ps

module testbench import qrs_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 120;

  typedef struct {
    logic [1:0]             kind;
    logic [VALUE_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0] hi;
    logic                   sat;
  } roots_t;

  typedef struct {
    logic [VALUE_WIDTH-1:0] a;
    logic [VALUE_WIDTH-1:0] b;
    logic [VALUE_WIDTH-1:0] c;
    bit                     typed;
    roots_t                 want;
  } row_t;

  logic                   clk_i = 0;
  logic                   rst_ni = 0;
  logic                   in_valid_i = 0;
  logic                   in_ready_o;
  logic [VALUE_WIDTH-1:0] coef_quad_i = '0;
  logic [VALUE_WIDTH-1:0] coef_lin_i = '0;
  logic [VALUE_WIDTH-1:0] coef_const_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 0;
  logic [1:0]             root_kind_o;
  logic [VALUE_WIDTH-1:0] root_low_o;
  logic [VALUE_WIDTH-1:0] root_high_o;
  logic                   saturated_o;
  logic                   cfg_we_i = 0;
  logic [TOL_WIDTH-1:0]   cfg_zero_tolerance_i = '0;

  quadratic_root_solver dut (.*);

  always #2 clk_i = ~clk_i;

  longint unsigned tolerance = 1;
  roots_t          pending_roots[$];
  int              errors = 0;
  int              cycles = 0;
  int              send_idle = 0;
  int              recv_idle = 0;
  bit              hold_req = 0;
  int              hold_left = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit is_small(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    return m <= tolerance;
  endfunction

  function automatic longint qdiv(longint num, longint den, inout bit sat);
    logic [127:0] n, d, q, lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if (d == 0) return 0;
    q = (n << FRAC_BITS) / d;
    lim = neg ? 128'(1) << (VALUE_WIDTH - 1) : (128'(1) << (VALUE_WIDTH - 1)) - 1;
    if (q > lim) begin
      sat = 1;
      q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint isqrt(logic [127:0] d);
    logic [127:0] r, t;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      t = r | (128'(1) << i);
      if (t * t <= d) r = t;
    end
    return longint'(r);
  endfunction

  function automatic roots_t solve_quadratic(logic signed [31:0] a, logic signed [31:0] b,
                                             logic signed [31:0] c);
    longint sa, sb, sc, lo, hi, r, s, r1, r2;
    logic signed [127:0] wa, wb, wc, disc;
    logic [127:0] dmag;
    bit sat;
    roots_t res;
    sa = a; sb = b; sc = c;
    wa = sa; wb = sb; wc = sc;
    lo = 0; hi = 0; sat = 0;
    res.kind = KIND_NONE;
    if (is_small(sa)) begin
      if (is_small(sb)) res.kind = is_small(sc) ? KIND_INF : KIND_NONE;
      else begin
        res.kind = KIND_ONE;
        if (!is_small(sc)) lo = qdiv(-sc, sb, sat);
        hi = lo;
      end
    end else if (is_small(sc)) begin
      if (is_small(sb)) res.kind = KIND_ONE;
      else begin
        r = qdiv(-sb, sa, sat);
        res.kind = KIND_TWO;
        if (r < 0) lo = r; else hi = r;
      end
    end else begin
      disc = wb * wb - 4 * wa * wc;
      dmag = disc < 0 ? -disc : disc;
      if (dmag <= (128'(tolerance) << FRAC_BITS)) begin
        res.kind = KIND_ONE;
        lo = qdiv(-sb, 2 * sa, sat);
        hi = lo;
      end else if (disc < 0) res.kind = KIND_NONE;
      else begin
        s = isqrt(dmag);
        r1 = qdiv(-sb - s, 2 * sa, sat);
        r2 = qdiv(-sb + s, 2 * sa, sat);
        res.kind = KIND_TWO;
        lo = r1 < r2 ? r1 : r2;
        hi = r1 < r2 ? r2 : r1;
      end
    end
    if (res.kind == KIND_NONE || res.kind == KIND_INF) begin
      lo = 0; hi = 0; sat = 0;
    end
    res.lo = lo[31:0];
    res.hi = hi[31:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    errors++;
  endtask

  // result side
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left = 300;
    if (hold_left > 0) begin
      out_ready_i <= 0;
      hold_left = hold_left - 1;
      if (hold_left == 0) hold_req = 0;
    end else out_ready_i <= $urandom_range(99) >= recv_idle;
  end

  always @(negedge clk_i) begin
    roots_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_roots.size() == 0) begin
        report("unexpected item", 32'(root_kind_o), 32'(0));
      end else begin
        w = pending_roots.pop_front();
        if (root_kind_o !== w.kind) report("kind", 32'(root_kind_o), 32'(w.kind));
        if (root_low_o !== w.lo) report("low", root_low_o, w.lo);
        if (root_high_o !== w.hi) report("high", root_high_o, w.hi);
        if (saturated_o !== w.sat) report("sat", 32'(saturated_o), 32'(w.sat));
      end
    end
  end

  task automatic send(row_t r);
    bit took;
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i   <= 1;
    coef_quad_i  <= r.a;
    coef_lin_i   <= r.b;
    coef_const_i <= r.c;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    pending_roots.push_back(r.typed ? r.want : solve_quadratic(r.a, r.b, r.c));
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [15:0] v);
    cfg_we_i <= 1;
    cfg_zero_tolerance_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    tolerance = v;
  endtask

  function automatic logic [31:0] pick_coef();
    int t;
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(16)) - 8) << FRAC_BITS;
      2: return 0;
      3: begin
        t = $urandom_range(2 * tolerance + 4);
        return 32'(longint'(t) - longint'(tolerance) - 2);
      end
      4: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h1;
        endcase
      end
      default: return 32'($signed($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  function automatic row_t random_row();
    row_t r;
    longint k, r1, r2;
    r.typed = 0;
    if ($urandom_range(99) < 45) begin
      // build from two chosen roots
      k  = longint'($urandom_range(7)) - 3;
      if (k == 0) k = 1;
      k  = k << FRAC_BITS;
      r1 = longint'($urandom_range(40)) - 20;
      r2 = longint'($urandom_range(40)) - 20;
      r.a = 32'(k);
      r.b = 32'(-k * (r1 + r2));
      r.c = 32'(k * r1 * r2 + longint'($urandom_range(3)) - 1);
    end else begin
      r.a = pick_coef();
      r.b = pick_coef();
      r.c = pick_coef();
    end
    return r;
  endfunction

  localparam roots_t NONE_R = '{KIND_NONE, 32'h0, 32'h0, 1'b0};
  row_t directed[$] = '{
    '{32'h0, 32'h0, 32'h0, 1, '{KIND_INF, 32'h0, 32'h0, 1'b0}},
    '{32'h0, 32'h0, 32'h0005_0000, 1, NONE_R},
    '{32'h0, 32'h0001_0000, 32'hfffe_0000, 1, '{KIND_ONE, 32'h0002_0000, 32'h0002_0000, 1'b0}},
    '{32'h0001_0000, 32'h0, 32'h0, 1, '{KIND_ONE, 32'h0, 32'h0, 1'b0}},
    '{32'h0001_0000, 32'hfffd_0000, 32'h0, 1, '{KIND_TWO, 32'h0, 32'h0003_0000, 1'b0}},
    '{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 1,
      '{KIND_ONE, 32'h0001_0000, 32'h0001_0000, 1'b0}},
    '{32'h0001_0000, 32'h0, 32'h0001_0000, 1, NONE_R},
    '{32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 1,
      '{KIND_TWO, 32'h0001_0000, 32'h0002_0000, 1'b0}},
    '{32'h0, 32'h2, 32'h7fff_ffff, 1, '{KIND_ONE, 32'h8000_0000, 32'h8000_0000, 1'b1}},
    '{32'h1, 32'hffff_ffff, 32'h1, 1, '{KIND_INF, 32'h0, 32'h0, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, NONE_R},
    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, NONE_R},
    '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, NONE_R},
    '{32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 0, NONE_R},
    '{32'h0000_0002, 32'h7fff_ffff, 32'h8000_0000, 0, NONE_R},
    '{32'hffff_0000, 32'h0003_0000, 32'h0004_0000, 0, NONE_R},
    '{32'h0000_0100, 32'h0001_0000, 32'hffff_0000, 0, NONE_R},
    '{32'h0002_0000, 32'h0000_0003, 32'h0000_0002, 0, NONE_R}
  };

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (directed[i]) send(directed[i]);
    drain();

    set_tolerance(16'd0);
    send_idle = 31; recv_idle = 70;
    for (int i = 0; i < 130; i++) send(random_row());
    drain();

    set_tolerance(16'hffff);
    send_idle = 70; recv_idle = 31;
    for (int i = 0; i < 130; i++) begin
      send(random_row());
      if (i == 60) begin
        in_valid_i <= 0;
        while (pending_roots.size() != 0) @(posedge clk_i);
      end
    end
    drain();

    set_tolerance(16'($urandom_range(40)));
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 140; i++) begin
      if (i == 20) begin
        in_valid_i <= 0;
        @(negedge clk_i);
        hold_req = 1;
        @(posedge clk_i);
      end
      send(random_row());
    end
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
